>>> src/glzw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_pkg
// shared types and constants of the gif lzw code decoder
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int TABLE_DEPTH    = 4096;
	localparam int MAX_CODE_WIDTH = 12;
	localparam int ADDR_W         = $clog2(TABLE_DEPTH);
	localparam int CODE_W         = 12;
	localparam int LEN_W          = 13;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

	localparam logic [2:0] KIND_FIRST = 3'd0;
	localparam logic [2:0] KIND_KNOWN = 3'd1;
	localparam logic [2:0] KIND_KWKWK = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_END   = 3'd4;

	typedef struct packed {
		logic [7:0]       first;
		logic [LEN_W-1:0] len;
	} dict_entry_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [2:0]        kind;
		logic [LEN_W-1:0]  len;
		logic [7:0]        first;
		logic              err;
		logic              last;
	} result_t;

endpackage

>>> src/glzw_dict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_dict
// dictionary memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module glzw_dict (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [glzw_pkg::ADDR_W-1:0] wr_addr,
	input  glzw_pkg::dict_entry_t      wr_data,
	input  logic [glzw_pkg::ADDR_W-1:0] rd_addr,
	output glzw_pkg::dict_entry_t      rd_data
);
	import glzw_pkg::*;

	dict_entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/glzw_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_out_fifo
// small result queue in front of the output channel
// ----------------------------------------------------------------------------
module glzw_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  glzw_pkg::result_t           push_data,
	input  logic                        pop,
	output glzw_pkg::result_t           head,
	output logic                        not_empty,
	output logic [glzw_pkg::FIFO_AW:0]  count
);
	import glzw_pkg::*;

	result_t             buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	assign head      = buf_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

endmodule

>>> src/gif_lzw_code_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_code_decoder
// cuts lzw codes from gif image data and tracks the dictionary per code
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  input    in_valid / in_stall     data_byte, start_image
//  output   out_valid / out_stall   code_value, code_kind, string_length,
//                                   first_pixel, table_error, last_of_run
//
//  a byte is taken first, then the extract stage cuts each code that it
//  completes, one after another.
//  each code does one dictionary read and at most one write in the next cycle;
//  a read of the entry being written is forwarded.
//  after reset the state is that of root size 8; no clearing pass is needed.
//  input stalls while codes remain or the four-entry result queue is short.
// ----------------------------------------------------------------------------
module gif_lzw_code_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_image,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] code_value,
	output logic [2:0]  code_kind,
	output logic [12:0] string_length,
	output logic [7:0]  first_pixel,
	output logic        table_error,
	output logic        last_of_run
);
	import glzw_pkg::*;

	// extract stage state
	logic [19:0]       bitbuf_q;
	logic [4:0]        bitcnt_q;
	logic [1:0]        ncode_q;
	logic [3:0]        width_q;
	logic [12:0]       thr_q;
	logic [12:0]       next_free_q;
	logic              have_prev_q;
	logic [7:0]        block_rem_q;
	logic              finished_q;
	logic [3:0]        root_q;

	// resolve stage
	logic              v_s2;
	logic [CODE_W-1:0] code_s2;
	logic [2:0]        kind_s2;
	logic              err_s2;
	logic              last_s2;
	logic              root_s2;
	logic              wr_s2;
	logic [ADDR_W-1:0] wraddr_s2;
	logic              fwd_s2;
	dict_entry_t       fwdd_s2;

	logic [7:0]        prev_first_q;
	logic [LEN_W-1:0]  prev_len_q;

	logic [FIFO_AW:0]  fifo_cnt;
	logic              room;
	logic              pend;
	logic              ext;
	logic              accept;
	logic              pop;
	result_t           res;
	result_t           head;
	dict_entry_t       wr_data;
	dict_entry_t       rd_data;

	// extract stage combinational
	logic [11:0]       mask;
	logic [CODE_W-1:0] code;
	logic [12:0]       code13;
	logic [12:0]       roots;
	logic [2:0]        kind;
	logic              err;
	logic              add;
	logic              clr;
	logic              fin_new;
	logic [3:0]        width_n;
	logic [12:0]       thr_n;
	logic [12:0]       nf_n;
	logic [12:0]       nf_inc;
	logic [4:0]        cnt_n;
	logic              last;
	logic              rd_fwd;

	assign room   = ({1'b0, fifo_cnt} + {{(FIFO_AW+1){1'b0}}, v_s2})
		< (FIFO_AW+2)'(FIFO_DEPTH);
	assign pend   = !finished_q && (ncode_q != 2'd3) && (bitcnt_q >= {1'b0, width_q});
	assign ext    = pend && room;
	assign in_stall = pend || !room;
	assign accept = in_valid && !in_stall;

	assign mask   = ~(12'hfff << width_q);
	assign code   = bitbuf_q[11:0] & mask;
	assign code13 = {1'b0, code};
	assign roots  = 13'd1 << root_q;
	assign nf_inc = next_free_q + 13'd1;

	always_comb begin
		kind    = KIND_END;
		err     = 1'b0;
		add     = 1'b0;
		clr     = 1'b0;
		fin_new = 1'b0;
		if (code13 == roots) begin
			kind = KIND_CLEAR;
			clr  = 1'b1;
		end else if (code13 == roots + 13'd1) begin
			kind    = KIND_END;
			fin_new = 1'b1;
		end else if (code13 < next_free_q && !have_prev_q) begin
			kind = KIND_FIRST;
		end else if (code13 < next_free_q) begin
			kind = KIND_KNOWN;
			err  = (next_free_q >= 13'(TABLE_DEPTH));
			add  = !err;
		end else if (code13 == next_free_q && have_prev_q
				&& next_free_q < 13'(TABLE_DEPTH)) begin
			kind = KIND_KWKWK;
			add  = 1'b1;
		end else begin
			kind    = KIND_END;
			err     = 1'b1;
			fin_new = 1'b1;
		end
	end

	always_comb begin
		width_n = width_q;
		thr_n   = thr_q;
		nf_n    = next_free_q;
		if (clr) begin
			width_n = root_q + 4'd1;
			thr_n   = (roots << 1) - 13'd1;
			nf_n    = roots + 13'd2;
		end else if (add) begin
			nf_n = nf_inc;
			if (nf_inc > thr_q && width_q < 4'(MAX_CODE_WIDTH)) begin
				width_n = width_q + 4'd1;
				thr_n   = {thr_q[11:0], 1'b1};
			end
		end
		cnt_n = bitcnt_q - {1'b0, width_q};
		last  = fin_new || (ncode_q == 2'd2) || (cnt_n < {1'b0, width_n});
	end

	assign rd_fwd = wr_s2 && (wraddr_s2 == code[ADDR_W-1:0]);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitbuf_q    <= '0;
			bitcnt_q    <= '0;
			ncode_q     <= '0;
			width_q     <= 4'd9;
			thr_q       <= 13'd511;
			next_free_q <= 13'd258;
			have_prev_q <= 1'b0;
			block_rem_q <= '0;
			finished_q  <= 1'b0;
			root_q      <= 4'd8;
			v_s2        <= 1'b0;
		end else begin
			v_s2 <= 1'b0;
			if (accept) begin
				if (start_image) begin
					bitbuf_q    <= '0;
					bitcnt_q    <= '0;
					ncode_q     <= '0;
					block_rem_q <= '0;
					have_prev_q <= 1'b0;
					if (data_byte >= 8'd2 && data_byte <= 8'd8) begin
						root_q      <= data_byte[3:0];
						width_q     <= data_byte[3:0] + 4'd1;
						thr_q       <= (13'd2 << data_byte[3:0]) - 13'd1;
						next_free_q <= (13'd1 << data_byte[3:0]) + 13'd2;
						finished_q  <= 1'b0;
					end else begin
						root_q      <= 4'd8;
						width_q     <= 4'd9;
						thr_q       <= 13'd511;
						next_free_q <= 13'd258;
						finished_q  <= 1'b1;
						v_s2        <= 1'b1;
					end
				end else if (!finished_q) begin
					if (block_rem_q == 8'd0) begin
						block_rem_q <= data_byte;
					end else begin
						block_rem_q <= block_rem_q - 8'd1;
						bitbuf_q    <= bitbuf_q | (20'(data_byte) << bitcnt_q);
						bitcnt_q    <= bitcnt_q + 5'd8;
						ncode_q     <= '0;
					end
				end
			end else if (ext) begin
				v_s2        <= 1'b1;
				width_q     <= width_n;
				thr_q       <= thr_n;
				next_free_q <= nf_n;
				ncode_q     <= ncode_q + 2'd1;
				if (clr) begin
					have_prev_q <= 1'b0;
				end else if (kind == KIND_FIRST) begin
					have_prev_q <= 1'b1;
				end
				if (fin_new) begin
					finished_q <= 1'b1;
					bitbuf_q   <= '0;
					bitcnt_q   <= '0;
				end else begin
					bitbuf_q <= bitbuf_q >> width_q;
					bitcnt_q <= cnt_n;
				end
			end
		end
	end

	// resolve stage payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s2 <= 1'b0;
		end else begin
			wr_s2 <= ext && add;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s2 <= '0;
			kind_s2 <= KIND_END;
			err_s2  <= 1'b1;
			last_s2 <= 1'b1;
			root_s2 <= 1'b0;
		end else begin
			code_s2 <= code;
			kind_s2 <= kind;
			err_s2  <= err;
			last_s2 <= last;
			root_s2 <= code13 < roots;
		end
		wraddr_s2 <= next_free_q[ADDR_W-1:0];
		fwd_s2    <= rd_fwd;
		fwdd_s2   <= wr_data;
	end

	assign wr_data.first = prev_first_q;
	assign wr_data.len   = prev_len_q + 13'd1;

	always_comb begin
		res.code  = code_s2;
		res.kind  = kind_s2;
		res.err   = err_s2;
		res.last  = last_s2;
		res.first = '0;
		res.len   = '0;
		case (kind_s2)
			KIND_FIRST, KIND_KNOWN: begin
				if (root_s2) begin
					res.first = code_s2[7:0];
					res.len   = 13'd1;
				end else if (fwd_s2) begin
					res.first = fwdd_s2.first;
					res.len   = fwdd_s2.len;
				end else begin
					res.first = rd_data.first;
					res.len   = rd_data.len;
				end
			end
			KIND_KWKWK: begin
				res.first = wr_data.first;
				res.len   = wr_data.len;
			end
			default: begin
				res.first = '0;
				res.len   = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v_s2 && (kind_s2 == KIND_FIRST || kind_s2 == KIND_KNOWN
				|| kind_s2 == KIND_KWKWK)) begin
			prev_first_q <= res.first;
			prev_len_q   <= res.len;
		end
	end

	glzw_dict u_dict (
		.clk     (clk),
		.wr_en   (wr_s2),
		.wr_addr (wraddr_s2),
		.wr_data (wr_data),
		.rd_addr (code[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	assign pop = out_valid && !out_stall;

	glzw_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s2),
		.push_data (res),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.count     (fifo_cnt)
	);

	assign code_value    = head.code;
	assign code_kind     = head.kind;
	assign string_length = head.len;
	assign first_pixel   = head.first;
	assign table_error   = head.err;
	assign last_of_run   = head.last;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the gif lzw code decoder: builds lzw image streams
// with random content, packs them into sub-blocks, predicts every code report
// and compares each output transaction field by field
// ----------------------------------------------------------------------------
import glzw_pkg::*;

class lzw_code_tracker;
	bit [7:0]  ent_first [TABLE_DEPTH];
	bit [12:0] ent_len [TABLE_DEPTH];
	bit [31:0] bit_acc;
	int        bit_cnt, width, grow_at, next_code, prev_code, root_bits, block_left;
	bit        have_prev, done;
	result_t   pending_q[$];
	int        errors, checked, bytes_seen;
	int        kind_cnt [5];

	function new();
		restart(8);
	endfunction

	function void wipe_table();
		int roots;
		roots = 1 << root_bits;
		for (int i = 0; i < roots; i++) begin
			ent_first[i] = i[7:0];
			ent_len[i] = 13'd1;
		end
		width = root_bits + 1;
		grow_at = 2 * roots - 1;
		next_code = roots + 2;
		have_prev = 0;
		prev_code = 0;
	endfunction

	function void restart(int rs);
		bit_acc = 0;
		bit_cnt = 0;
		block_left = 0;
		done = 0;
		root_bits = rs;
		wipe_table();
	endfunction

	function bit grow(int prefix, bit [7:0] b);
		if (next_code >= TABLE_DEPTH) return 1;
		ent_first[next_code] = ent_first[prefix];
		ent_len[next_code] = ent_len[prefix] + 13'd1;
		next_code++;
		if (next_code > grow_at && width < MAX_CODE_WIDTH) begin
			width++;
			grow_at = 2 * grow_at + 1;
		end
		return 0;
	endfunction

	function void push(int code, logic [2:0] kind, bit [12:0] len, bit [7:0] f, bit err);
		result_t r;
		r.code = code[11:0];
		r.kind = kind;
		r.len = len;
		r.first = f;
		r.err = err;
		r.last = 0;
		pending_q.push_back(r);
	endfunction

	function void decode(int code);
		int cc;
		bit full;
		bit [7:0] f;
		cc = 1 << root_bits;
		if (code == cc) begin
			wipe_table();
			push(code, KIND_CLEAR, 0, 0, 0);
		end else if (code == cc + 1) begin
			done = 1;
			push(code, KIND_END, 0, 0, 0);
		end else if (code < next_code && !have_prev) begin
			push(code, KIND_FIRST, ent_len[code], ent_first[code], 0);
			prev_code = code;
			have_prev = 1;
		end else if (code < next_code) begin
			full = grow(prev_code, ent_first[code]);
			push(code, KIND_KNOWN, ent_len[code], ent_first[code], full);
			prev_code = code;
		end else if (code == next_code && have_prev && next_code < TABLE_DEPTH) begin
			f = ent_first[prev_code];
			full = grow(prev_code, f);
			push(code, KIND_KWKWK, ent_len[code], f, 0);
			prev_code = code;
		end else begin
			done = 1;
			push(code, KIND_END, 0, 0, 1);
		end
	endfunction

	function void note_byte(bit [7:0] b, bit s);
		int n, code;
		result_t r;
		bytes_seen++;
		if (s) begin
			if (b >= 2 && b <= 8) begin
				restart(b);
				return;
			end
			restart(8);
			done = 1;
			push(0, KIND_END, 0, 0, 1);
			n = 1;
		end else begin
			if (done) return;
			if (block_left == 0) begin
				block_left = b;
				return;
			end
			block_left--;
			bit_acc |= 32'(b) << bit_cnt;
			bit_cnt += 8;
			n = 0;
			while (!done && n < 3 && bit_cnt >= width) begin
				code = bit_acc & ((1 << width) - 1);
				bit_acc >>= width;
				bit_cnt -= width;
				decode(code);
				n++;
			end
			if (done) begin
				bit_acc = 0;
				bit_cnt = 0;
			end
		end
		if (n > 0) begin
			r = pending_q.pop_back();
			r.last = 1;
			pending_q.push_back(r);
		end
	endfunction

	function void cmp(string nm, int e, int a);
		if (e != a) begin
			errors++;
			$display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, a);
		end
	endfunction

	function void check_code(result_t a);
		result_t e;
		if (pending_q.size() == 0) begin
			errors++;
			$display("%0t unexpected transaction code %0d kind %0d", $time, a.code, a.kind);
			return;
		end
		e = pending_q.pop_front();
		checked++;
		if (e.kind < 5) kind_cnt[e.kind]++;
		cmp("code_value", e.code, a.code);
		cmp("code_kind", e.kind, a.kind);
		cmp("string_length", e.len, a.len);
		cmp("first_pixel", e.first, a.first);
		cmp("table_error", e.err, a.err);
		cmp("last_of_run", e.last, a.last);
	endfunction
endclass

module testbench;
	localparam int CYCLE_LIMIT = 1500000;

	logic        clk, arst_n;
	logic        in_valid, in_stall, start_image;
	logic [7:0]  data_byte;
	logic        out_valid, out_stall;
	logic [11:0] code_value;
	logic [2:0]  code_kind;
	logic [12:0] string_length;
	logic [7:0]  first_pixel;
	logic        table_error, last_of_run;

	lzw_code_tracker tracker = new();
	bit [8:0] stim_q[$];
	bit [7:0] payload_q[$];
	bit       quiet;
	int       stall_left, cycles, images;

	gif_lzw_code_decoder u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .start_image(start_image),
		.out_valid(out_valid), .out_stall(out_stall),
		.code_value(code_value), .code_kind(code_kind),
		.string_length(string_length), .first_pixel(first_pixel),
		.table_error(table_error), .last_of_run(last_of_run)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_code('{code_value, code_kind, string_length, first_pixel,
				table_error, last_of_run});
			stall_left = quiet ? 0 : $urandom_range(0, 5);
		end
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1;
			stall_left--;
		end else begin
			out_stall = 0;
		end
	end

	task automatic send_all();
		int gap;
		while (stim_q.size() > 0) begin
			gap = quiet ? 0 : $urandom_range(0, 5);
			@(negedge clk);
			repeat (gap) begin
				in_valid = 0;
				@(negedge clk);
			end
			{start_image, data_byte} = stim_q.pop_front();
			in_valid = 1;
			do @(posedge clk); while (in_stall);
			tracker.note_byte(data_byte, start_image);
		end
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic wait_drain();
		while (tracker.pending_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// pack codes lsb first, then split into sub-blocks
	task automatic build_image(int rs, int ncodes, int mode);
		int roots, nf, w, thr, code, nacc, len, idx;
		bit hp;
		bit [31:0] acc;
		roots = 1 << rs;
		nf = roots + 2; w = rs + 1; thr = 2 * roots - 1; hp = 0;
		acc = 0; nacc = 0;
		payload_q.delete();
		stim_q.push_back({1'b1, 8'(rs)});
		for (int i = 0; i <= ncodes; i++) begin
			if (i == ncodes) begin
				if (mode == 1) code = (nf + 1 < (1 << w)) ? $urandom_range(nf + 1, (1 << w) - 1)
					: roots;
				else if (mode == 2) code = hp ? nf : roots;
				else code = roots + 1;
				if (mode == 2 && !hp) begin
					acc |= 32'(code) << nacc; nacc += w;
					code = roots + 2;
				end
			end else if (!hp) begin
				code = $urandom_range(0, roots - 1);
			end else if (mode != 3 && $urandom_range(0, 29) == 0) begin
				code = roots;
			end else if ($urandom_range(0, 9) == 0 && nf < TABLE_DEPTH) begin
				code = nf;
			end else begin
				code = $urandom_range(0, nf - 1);
				if (code == roots || code == roots + 1) code = $urandom_range(0, roots - 1);
			end
			acc |= 32'(code) << nacc;
			nacc += w;
			while (nacc >= 8) begin
				payload_q.push_back(acc[7:0]);
				acc >>= 8;
				nacc -= 8;
			end
			if (i < ncodes) begin
				if (code == roots) begin
					nf = roots + 2; w = rs + 1; thr = 2 * roots - 1; hp = 0;
				end else if (!hp) begin
					hp = 1;
				end else if (nf < TABLE_DEPTH) begin
					nf++;
					if (nf > thr && w < MAX_CODE_WIDTH) begin
						w++;
						thr = 2 * thr + 1;
					end
				end
			end
		end
		if (nacc > 0) payload_q.push_back(acc[7:0] | 8'($urandom) << nacc);
		idx = 0;
		while (idx < payload_q.size()) begin
			if ($urandom_range(0, 7) == 0) stim_q.push_back(9'h000);
			len = (mode == 3) ? $urandom_range(1, 255) : $urandom_range(1, 12);
			if (len > payload_q.size() - idx) len = payload_q.size() - idx;
			stim_q.push_back({1'b0, 8'(len)});
			repeat (len) stim_q.push_back({1'b0, payload_q[idx++]});
		end
		stim_q.push_back(9'h000);
		stim_q.push_back({1'b0, 8'($urandom)});
		images++;
	endtask

	initial begin
		int sel;
		arst_n = 0;
		in_valid = 0;
		data_byte = 0;
		start_image = 0;
		out_stall = 0;
		stall_left = 0;
		quiet = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// payload straight after reset, root size 8 state
		stim_q = '{9'h003, 9'h041, 9'h0ff, 9'h080, 9'h002, 9'h001, 9'h003};
		// invalid root sizes, then ignored bytes
		stim_q.push_back(9'h100);
		stim_q.push_back(9'h0ff);
		stim_q.push_back(9'h101);
		stim_q.push_back(9'h109);
		stim_q.push_back(9'h1ff);
		stim_q.push_back(9'h055);
		send_all();
		build_image(8, 6, 0);
		build_image(2, 10, 0);
		send_all();
		wait_drain();
		build_image(2, 4, 1);
		build_image(5, 4, 2);
		build_image(3, 0, 2);
		send_all();

		while (tracker.bytes_seen < 350) begin
			quiet = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				build_image($urandom_range(2, 8), $urandom_range(3, 40), 0);
			end else if (sel < 8) begin
				build_image($urandom_range(2, 8), $urandom_range(1, 20), $urandom_range(1, 2));
			end else begin
				stim_q.push_back({1'b1, 8'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(2, 8))});
				repeat ($urandom_range(5, 25)) stim_q.push_back({1'($urandom_range(0, 15) == 0),
					8'($urandom)});
			end
			send_all();
			if ($urandom_range(0, 3) == 0) wait_drain();
		end
		quiet = 0;
		build_image(8, 20, 0);
		send_all();

		wait_drain();
		repeat (20) @(posedge clk);
		if (tracker.pending_q.size() > 0) begin
			tracker.errors++;
			$display("%0t %0d expected transactions never arrived", $time,
				tracker.pending_q.size());
		end
		$display("%0d bytes over %0d images, %0d code reports checked", tracker.bytes_seen,
			images, tracker.checked);
		$display("kinds first %0d known %0d kwkwk %0d clear %0d end %0d",
			tracker.kind_cnt[0], tracker.kind_cnt[1], tracker.kind_cnt[2],
			tracker.kind_cnt[3], tracker.kind_cnt[4]);
		if (tracker.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

>>> files.f
src/glzw_pkg.sv
src/glzw_dict.sv
src/glzw_out_fifo.sv
src/gif_lzw_code_decoder.sv
tb/sv/testbench.sv
